// File: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define UFJ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also checks behavior during reset
`define UFJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ufj_pkg.sv
// shared widths, constants and controller/datapath interface types
package ufj_pkg;

    localparam int NODE_W = 10;
    localparam int SIZE_W = 11;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    typedef struct packed {
        logic clear_wr;
        logic load_in;
        logic sel_b;
        logic walk_start;
        logic walk_step;
        logic set_root;
        logic comp_write;
        logic size_rd_a;
        logic size_rd_b;
        logic do_merge;
        logic load_out;
    } ufj_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic at_root;
        logic at_target;
        logic a_ok;
        logic b_ok;
        logic roots_differ;
        logic out_free;
    } ufj_sts_t;

endpackage

// File: rtl/core/ufj_datapath.sv
// parent and size tables, walk registers, merge arithmetic and result register
module ufj_datapath
    import ufj_pkg::*;
#(
    parameter int NODES = 1024,
    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ufj_cmd_t             cmd,
    output ufj_sts_t             sts,
    input  logic [NODE_W-1:0]    in_node_a,
    input  logic [NODE_W-1:0]    in_node_b,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_DATA_W-1:0]  m_tdata
);

    logic [IW-1:0]     parent_mem [NODES];
    logic [SIZE_W-1:0] size_mem   [NODES];

    logic [NODE_W-1:0] a_reg, b_reg;
    logic              a_ok_reg, b_ok_reg;
    logic [IW-1:0]     cur_reg, par_q, ra_reg, rb_reg, clr_reg;
    logic [SIZE_W-1:0] size_q, sa_reg;
    logic              merged_reg;
    logic              out_merged_reg;
    logic [NODE_W-1:0] out_ra_reg, out_rb_reg;
    logic              m_tvalid_reg;

    logic [IW-1:0]     start_idx, root_sel, rd_addr;
    logic [IW-1:0]     big_idx, small_idx, sz_rd_addr;
    logic              a_small;
    logic [SIZE_W:0]   size_sum;
    logic [SIZE_W-1:0] size_sat;

    logic              p_we, s_we;
    logic [IW-1:0]     p_wa, p_wd, s_wa;
    logic [SIZE_W-1:0] s_wd;

    assign start_idx = cmd.sel_b ? IW'(b_reg) : IW'(a_reg);
    assign root_sel  = cmd.sel_b ? rb_reg : ra_reg;
    assign rd_addr   = cmd.walk_start ? start_idx : par_q;

    // size_q holds the size of the b root here, sa_reg that of the a root
    assign a_small   = sa_reg < size_q;
    assign big_idx   = a_small ? rb_reg : ra_reg;
    assign small_idx = a_small ? ra_reg : rb_reg;
    assign size_sum  = {1'b0, sa_reg} + {1'b0, size_q};
    assign size_sat  = (size_sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : size_sum[SIZE_W-1:0];
    assign sz_rd_addr = cmd.size_rd_a ? ra_reg : rb_reg;

    always_comb begin
        p_we = 1'b0;
        p_wa = clr_reg;
        p_wd = clr_reg;
        if (cmd.clear_wr) begin
            p_we = 1'b1;
        end else if (cmd.comp_write) begin
            p_we = 1'b1;
            p_wa = cur_reg;
            p_wd = root_sel;
        end else if (cmd.do_merge) begin
            p_we = 1'b1;
            p_wa = small_idx;
            p_wd = big_idx;
        end
    end

    always_comb begin
        s_we = 1'b0;
        s_wa = clr_reg;
        s_wd = SIZE_ONE;
        if (cmd.clear_wr) begin
            s_we = 1'b1;
        end else if (cmd.do_merge) begin
            s_we = 1'b1;
            s_wa = big_idx;
            s_wd = size_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            parent_mem[p_wa] <= p_wd;
        end
        if (cmd.walk_start || cmd.walk_step) begin
            par_q <= parent_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_we) begin
            size_mem[s_wa] <= s_wd;
        end
        if (cmd.size_rd_a || cmd.size_rd_b) begin
            size_q <= size_mem[sz_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            a_reg      <= in_node_a;
            b_reg      <= in_node_b;
            a_ok_reg   <= 32'(in_node_a) < NODES;
            b_ok_reg   <= 32'(in_node_b) < NODES;
            merged_reg <= 1'b0;
        end else if (cmd.do_merge) begin
            merged_reg <= 1'b1;
        end
        if (cmd.walk_start) begin
            cur_reg <= start_idx;
        end else if (cmd.walk_step) begin
            cur_reg <= par_q;
        end
        if (cmd.set_root) begin
            if (cmd.sel_b) begin
                rb_reg <= cur_reg;
            end else begin
                ra_reg <= cur_reg;
            end
        end
        if (cmd.size_rd_b) begin
            sa_reg <= size_q;
        end
        if (cmd.load_out) begin
            out_merged_reg <= merged_reg;
            // an element outside the table reports itself as its root
            out_ra_reg     <= a_ok_reg ? NODE_W'(ra_reg) : a_reg;
            out_rb_reg     <= b_ok_reg ? NODE_W'(rb_reg) : b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_reg <= clr_reg + IW'(1);
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last     = clr_reg == IW'(NODES - 1);
    assign sts.at_root      = par_q == cur_reg;
    assign sts.at_target    = cur_reg == root_sel;
    assign sts.a_ok         = a_ok_reg;
    assign sts.b_ok         = b_ok_reg;
    assign sts.roots_differ = ra_reg != rb_reg;
    assign sts.out_free     = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - 2*NODE_W - 1){1'b0}}, out_rb_reg, out_ra_reg, out_merged_reg};

endmodule

// File: rtl/core/ufj_ctrl.sv
// sequencing state machine: clearing pass, root walks, compression, merge
module ufj_ctrl
    import ufj_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ufj_sts_t sts,
    output ufj_cmd_t cmd
);

    localparam logic [3:0] ST_CLEAR      = 4'd0;
    localparam logic [3:0] ST_IDLE       = 4'd1;
    localparam logic [3:0] ST_START      = 4'd2;
    localparam logic [3:0] ST_FIND_ISSUE = 4'd3;
    localparam logic [3:0] ST_FIND_WALK  = 4'd4;
    localparam logic [3:0] ST_COMP_ISSUE = 4'd5;
    localparam logic [3:0] ST_COMP_WALK  = 4'd6;
    localparam logic [3:0] ST_SIZE_A     = 4'd7;
    localparam logic [3:0] ST_SIZE_B     = 4'd8;
    localparam logic [3:0] ST_MERGE      = 4'd9;
    localparam logic [3:0] ST_RESULT     = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       side_reg, side_next;

    always_comb begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd        = '0;
        cmd.sel_b  = side_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START: begin
                if (sts.a_ok) begin
                    side_next  = 1'b0;
                    state_next = ST_FIND_ISSUE;
                end else if (sts.b_ok) begin
                    side_next  = 1'b1;
                    state_next = ST_FIND_ISSUE;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_FIND_ISSUE: begin
                cmd.walk_start = 1'b1;
                state_next     = ST_FIND_WALK;
            end
            ST_FIND_WALK: begin
                if (sts.at_root) begin
                    cmd.set_root = 1'b1;
                    state_next   = ST_COMP_ISSUE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_COMP_ISSUE: begin
                cmd.walk_start = 1'b1;
                state_next     = ST_COMP_WALK;
            end
            ST_COMP_WALK: begin
                if (sts.at_target) begin
                    if (!side_reg && sts.b_ok) begin
                        side_next  = 1'b1;
                        state_next = ST_FIND_ISSUE;
                    end else if (sts.a_ok && sts.b_ok && sts.roots_differ) begin
                        state_next = ST_SIZE_A;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    // point this node at the root, follow its old link
                    cmd.comp_write = 1'b1;
                    cmd.walk_step  = 1'b1;
                end
            end
            ST_SIZE_A: begin
                cmd.size_rd_a = 1'b1;
                state_next    = ST_SIZE_B;
            end
            ST_SIZE_B: begin
                cmd.size_rd_b = 1'b1;
                state_next    = ST_MERGE;
            end
            ST_MERGE: begin
                cmd.do_merge = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            side_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

endmodule

// File: rtl/core/union_find_join.sv
// top level of the disjoint-set join engine
// After reset the block sweeps its parent and size tables, one entry per cycle, with
// s_tready low. Each word then names two elements; the block walks each one's
// parent chain to its root, walks it again pointing every node at the root, and if the
// roots differ hangs the smaller set under the larger one (the second root under the first
// on a tie). The walks are paced by the single read port of the parent table, one link
// per cycle. An element not below NODES is its own root, is never joined and costs no
// walk. A finished result waits in the output register while the next word is accepted.
module union_find_join
    import ufj_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // node_a, node_b, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // merged, root_a, root_b, zero pad
);

    ufj_cmd_t cmd;
    ufj_sts_t sts;

    ufj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ufj_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_node_a (s_tdata[NODE_W-1:0]),
        .in_node_b (s_tdata[2*NODE_W-1:NODE_W]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/core/ufj_checker.sv
// port-level checks for the join engine, bound to the top level
`include "assert_macros.svh"

module ufj_checker
    import ufj_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a merge always joins two different roots
    `UFJ_ASSERT(a_merge_roots_differ, aclk, aresetn, m_tvalid && m_tdata[0] |-> m_tdata[NODE_W:1] != m_tdata[2*NODE_W:NODE_W+1], "merge reported with equal roots")

    // table sweep keeps the input closed and the output empty right after reset
    `UFJ_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !s_tready && !m_tvalid, "block active right after reset")

    `UFJ_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result word changed")

    // one item in flight: no new word is taken in the cycle after an accept
    `UFJ_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input accepted twice in a row")

endmodule

bind union_find_join ufj_checker u_ufj_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/union_find_join_checker.sv
// checker for the disjoint-set join engine: predicts each result word and compares it
module union_find_join_checker
    import ufj_pkg::*;
#(
    parameter int NODES = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                end_of_test,
    output int                  fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [NODE_W-1:0] node_b;
        logic [NODE_W-1:0] node_a;
    } node_pair_t;

    typedef struct packed {
        logic [NODE_W-1:0] root_b;
        logic [NODE_W-1:0] root_a;
        logic              merged;
    } join_result_t;

    localparam int MAX_SHOWN = 10;

    logic [NODE_W-1:0] parent_of [NODES];
    logic [SIZE_W-1:0] set_size  [NODES];
    join_result_t      joins_due [$];
    int                mismatches = 0;
    bit                end_checked = 1'b0;

    assign fail_count = mismatches;

    function automatic bit in_table(input logic [NODE_W-1:0] node);
        return int'(node) < NODES;
    endfunction

    function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] start);
        logic [NODE_W-1:0] node;
        int                steps;
        node  = start;
        steps = 0;
        while (parent_of[node] != node && steps < NODES) begin
            node = parent_of[node];
            steps++;
        end
        return node;
    endfunction

    // second pass over the same chain, pointing every node at the root
    function automatic void flatten_path(input logic [NODE_W-1:0] start,
                                         input logic [NODE_W-1:0] root);
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] next;
        int                steps;
        node  = start;
        steps = 0;
        while (node != root && steps < NODES) begin
            next            = parent_of[node];
            parent_of[node] = root;
            node            = next;
            steps++;
        end
    endfunction

    function automatic join_result_t predict_join(input node_pair_t pair);
        join_result_t      res;
        logic [NODE_W-1:0] big;
        logic [NODE_W-1:0] little;
        logic [SIZE_W:0]   sum;
        bit                a_ok;
        bit                b_ok;
        a_ok       = in_table(pair.node_a);
        b_ok       = in_table(pair.node_b);
        res.merged = 1'b0;
        res.root_a = pair.node_a;
        res.root_b = pair.node_b;
        if (a_ok) begin
            res.root_a = find_root(pair.node_a);
            flatten_path(pair.node_a, res.root_a);
        end
        if (b_ok) begin
            res.root_b = find_root(pair.node_b);
            flatten_path(pair.node_b, res.root_b);
        end
        if (a_ok && b_ok && res.root_a != res.root_b) begin
            // smaller set goes under the larger, second root under the first on a tie
            big    = res.root_a;
            little = res.root_b;
            if (set_size[res.root_a] < set_size[res.root_b]) begin
                big    = res.root_b;
                little = res.root_a;
            end
            parent_of[little] = big;
            sum = set_size[big] + set_size[little];
            set_size[big] = (sum > SIZE_MAX) ? SIZE_MAX : sum[SIZE_W-1:0];
            res.merged = 1'b1;
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input join_result_t want,
                                 input join_result_t got);
        if (mismatches < MAX_SHOWN) begin
            $display("%0t: %s: expected merged=%0d root_a=%0d root_b=%0d, %s%0d%s%0d%s%0d",
                     $realtime, what, want.merged, want.root_a, want.root_b,
                     "got merged=", got.merged, " root_a=", got.root_a,
                     " root_b=", got.root_b);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin : watch
        join_result_t got;
        join_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                parent_of[i] = NODE_W'(i);
                set_size[i]  = SIZE_ONE;
            end
            joins_due.delete();
        end else begin
            // result word first: it can only belong to an earlier input word
            if (m_tvalid && m_tready) begin
                got = join_result_t'(m_tdata[2*NODE_W:0]);
                if (joins_due.size() == 0) begin
                    note_mismatch("result word with nothing pending", '0, got);
                end else begin
                    want = joins_due.pop_front();
                    if (got.merged !== want.merged || got.root_a !== want.root_a ||
                        got.root_b !== want.root_b) begin
                        note_mismatch("result word differs", want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want      = predict_join(node_pair_t'(s_tdata[2*NODE_W-1:0]));
                joins_due = {joins_due, want};
            end
            if (end_of_test && !end_checked) begin
                end_checked = 1'b1;
                if (joins_due.size() != 0) begin
                    note_mismatch("results still pending at end", joins_due[0], '0);
                end
            end
        end
    end

endmodule

// File: bench/union_find_join_tb.sv
// testbench top for the disjoint-set join engine: clock, reset, stimulus and verdict
module union_find_join_tb;
    import ufj_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES       = 1024;
    localparam int TOTAL_ITEMS = 1275;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT    = 22;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                end_of_test = 1'b0;
    int                  fail_count;

    int items_sent   = 0;
    int results_seen = 0;
    bit sender_calm  = 1'b0;

    union_find_join #(
        .NODES(NODES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    union_find_join_checker #(
        .NODES(NODES)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .end_of_test(end_of_test),
        .fail_count (fail_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

    // result side: random stalls, one long hold-off, and a calm stretch
    initial begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && results_seen >= 350) begin
                hold_left = 320;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (results_seen >= 800 && results_seen < 1000) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_pair(input logic [NODE_W-1:0] node_a, input logic [NODE_W-1:0] node_b);
        if (!sender_calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - 2*NODE_W){1'b0}}, node_b, node_a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_seen != items_sent) @(posedge aclk);
    endtask

    // equal-size joins at doubling strides give a tree of depth log2(count)
    task automatic build_tree(input int base, input int count);
        for (int stride = 1; stride < count; stride *= 2) begin
            for (int i = 0; i < count; i += 2 * stride) begin
                send_pair(NODE_W'(base + i), NODE_W'(base + i + stride));
            end
        end
    endtask

    initial begin : stimulus
        int  blk;
        int  base;
        int  lo;
        int  span;
        int  pick;
        int  n;
        bit  mid_pause_done;
        mid_pause_done = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: deep tree, deep find, same-set query, extremes, both size orders
        build_tree(0, 16);
        send_pair(10'd15, 10'd15);
        send_pair(10'd15, 10'd7);
        send_pair(10'd0, 10'd0);
        send_pair(10'd1023, 10'd1023);
        send_pair(10'd1023, 10'd0);
        send_pair(10'd0, 10'd1022);
        send_pair(10'd512, 10'd0);
        send_pair(10'd1022, 10'd1023);
        send_pair(10'd341, 10'd682);
        wait_for_drain();

        while (items_sent < TOTAL_ITEMS) begin
            if (!mid_pause_done && items_sent >= 650) begin
                wait_for_drain();
                mid_pause_done = 1'b1;
            end
            sender_calm = (items_sent >= 750 && items_sent < 950);
            if ($urandom_range(99) < 30) begin
                blk  = 8 << $urandom_range(2);
                base = blk * $urandom_range(NODES / blk - 1);
                build_tree(base, blk);
                repeat (4) begin
                    n = base + $urandom_range(blk - 1);
                    send_pair(NODE_W'(n), NODE_W'(n));
                end
            end else begin
                span = $urandom_range(8, 48);
                lo   = $urandom_range(NODES - span);
                repeat ($urandom_range(20, 40)) begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        send_pair(NODE_W'(lo + $urandom_range(span - 1)),
                                  NODE_W'(lo + $urandom_range(span - 1)));
                    end else if (pick < 80) begin
                        n = lo + $urandom_range(span - 1);
                        send_pair(NODE_W'(n), NODE_W'(n));
                    end else begin
                        send_pair(NODE_W'($urandom_range(NODES - 1)),
                                  NODE_W'($urandom_range(NODES - 1)));
                    end
                end
            end
        end
        s_tvalid <= 1'b0;

        while (results_seen != items_sent) @(posedge aclk);
        repeat (80) @(posedge aclk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
